/* sv/tlvkap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV key attribute parser package
// Shared types, tag codes and the capture size table for the key blob parser.
// ----------------------------------------------------------------------------
package tlvkap_pkg;

    localparam int unsigned MAX_BLOB_BYTES = 65535;
    localparam int unsigned COUNT_CAP = (MAX_BLOB_BYTES < 65535) ? MAX_BLOB_BYTES : 65535;
    localparam logic [15:0] COUNT_CAP_W = 16'(COUNT_CAP);

    localparam logic [7:0] TAG_KEY_ID    = 8'h41;
    localparam logic [7:0] TAG_ALGORITHM = 8'h42;
    localparam logic [7:0] TAG_USAGE     = 8'h43;
    localparam logic [7:0] TAG_KEY_TYPE  = 8'h44;
    localparam logic [7:0] TAG_BITS      = 8'h45;
    localparam logic [7:0] TAG_LIFETIME  = 8'h46;
    localparam logic [7:0] TAG_SIGNATURE = 8'h5E;

    localparam logic [2:0] CAPTURE_WORD = 3'd4;
    localparam logic [2:0] CAPTURE_HALF = 3'd2;
    localparam logic [2:0] CAPTURE_NONE = 3'd0;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_LEN1,
        PH_LENN,
        PH_VALUE,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        ST_SIGNATURE,
        ST_NO_SIGNATURE,
        ST_MALFORMED,
        ST_TRUNCATED
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] key_identifier;
        logic [31:0] algorithm;
        logic [31:0] usage_flags;
        logic [15:0] key_kind;
        logic [31:0] key_size_bits;
        logic [31:0] lifetime;
        logic [15:0] blob_bytes;
    } result_t;

    function automatic logic [2:0] capture_size(input logic [7:0] tag);
        logic [2:0] size;
        unique case (tag)
            TAG_KEY_ID, TAG_ALGORITHM, TAG_USAGE, TAG_BITS, TAG_LIFETIME: size = CAPTURE_WORD;
            TAG_KEY_TYPE: size = CAPTURE_HALF;
            default: size = CAPTURE_NONE;
        endcase
        return size;
    endfunction

endpackage

/* sv/tlvkap_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV key attribute parser channels
// Valid/ready channels for blob bytes in and parse results out.
// ----------------------------------------------------------------------------
interface tlvkap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlvkap_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] key_identifier;
    logic [31:0] algorithm;
    logic [31:0] usage_flags;
    logic [15:0] key_kind;
    logic [31:0] key_size_bits;
    logic [31:0] lifetime;
    logic [15:0] blob_bytes;

    modport source (
        output valid, output status, output key_identifier, output algorithm,
        output usage_flags, output key_kind, output key_size_bits, output lifetime,
        output blob_bytes, input ready
    );
    modport sink (
        input valid, input status, input key_identifier, input algorithm,
        input usage_flags, input key_kind, input key_size_bits, input lifetime,
        input blob_bytes, output ready
    );
endinterface

/* sv/tlvkap_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV key attribute parser core
// Per-byte record state, header length decode and attribute capture.
// ----------------------------------------------------------------------------
module tlvkap_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              fire,
    output tlvkap_pkg::result_t result,
    output logic              halted
);
    import tlvkap_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  current_tag_reg, current_tag_next;
    logic [31:0] field_length_reg, field_length_next;
    logic [2:0]  length_bytes_left_reg, length_bytes_left_next;
    logic [2:0]  value_index_reg, value_index_next;
    logic [31:0] value_shift_reg, value_shift_next;
    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [31:0] saved_key_id_reg, saved_key_id_next;
    logic [31:0] saved_algorithm_reg, saved_algorithm_next;
    logic [31:0] saved_usage_reg, saved_usage_next;
    logic [15:0] saved_type_reg, saved_type_next;
    logic [31:0] saved_bits_reg, saved_bits_next;
    logic [31:0] saved_lifetime_reg, saved_lifetime_next;

    logic        hdr_done;
    logic [31:0] hdr_len;
    logic [2:0]  need;
    logic [2:0]  hdr_need;
    logic [32:0] sig_end;
    logic        st_valid;
    status_t     st_code;
    logic [15:0] bytes;

    assign halted = (phase_reg == PH_HALT);

    always_comb
    begin
        phase_next             = phase_reg;
        current_tag_next       = current_tag_reg;
        field_length_next      = field_length_reg;
        length_bytes_left_next = length_bytes_left_reg;
        value_index_next       = value_index_reg;
        value_shift_next       = value_shift_reg;
        saved_key_id_next      = saved_key_id_reg;
        saved_algorithm_next   = saved_algorithm_reg;
        saved_usage_next       = saved_usage_reg;
        saved_type_next        = saved_type_reg;
        saved_bits_next        = saved_bits_reg;
        saved_lifetime_next    = saved_lifetime_reg;
        hdr_done               = 1'b0;
        hdr_len                = 32'd0;
        st_valid               = 1'b0;
        st_code                = ST_MALFORMED;
        need                   = capture_size(current_tag_reg);

        byte_offset_next = (byte_offset_reg < COUNT_CAP_W) ? byte_offset_reg + 16'd1
                                                           : byte_offset_reg;
        bytes = byte_offset_next;

        unique case (phase_reg)
            PH_TAG:
            begin
                current_tag_next = data_byte;
                phase_next       = PH_LEN1;
            end
            PH_LEN1:
            begin
                if (!data_byte[7])
                begin
                    hdr_len  = {24'd0, data_byte};
                    hdr_done = 1'b1;
                end
                else if (data_byte[6:0] >= 7'd1 && data_byte[6:0] <= 7'd4)
                begin
                    field_length_next      = 32'd0;
                    length_bytes_left_next = data_byte[2:0];
                    phase_next             = PH_LENN;
                end
                else
                begin
                    phase_next = PH_HALT;
                    st_valid   = 1'b1;
                    st_code    = ST_MALFORMED;
                end
            end
            PH_LENN:
            begin
                field_length_next      = {field_length_reg[23:0], data_byte};
                length_bytes_left_next = length_bytes_left_reg - 3'd1;
                if (length_bytes_left_reg == 3'd1)
                begin
                    hdr_len  = field_length_next;
                    hdr_done = 1'b1;
                end
            end
            PH_VALUE:
            begin
                if (value_index_reg < need)
                begin
                    value_shift_next = {value_shift_reg[23:0], data_byte};
                    value_index_next = value_index_reg + 3'd1;
                    if (value_index_next == need)
                    begin
                        unique case (current_tag_reg)
                            TAG_KEY_ID:    saved_key_id_next    = value_shift_next;
                            TAG_ALGORITHM: saved_algorithm_next = value_shift_next;
                            TAG_USAGE:     saved_usage_next     = value_shift_next;
                            TAG_KEY_TYPE:  saved_type_next      = value_shift_next[15:0];
                            TAG_BITS:      saved_bits_next      = value_shift_next;
                            TAG_LIFETIME:  saved_lifetime_next  = value_shift_next;
                            default:       saved_key_id_next    = saved_key_id_reg;
                        endcase
                    end
                end
                field_length_next = field_length_reg - 32'd1;
                if (field_length_next == 32'd0)
                    phase_next = PH_TAG;
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase

        hdr_need = capture_size(current_tag_next);
        sig_end  = {17'd0, byte_offset_next} + {1'b0, hdr_len};

        if (hdr_done)
        begin
            field_length_next = hdr_len;
            if (current_tag_next == TAG_SIGNATURE)
            begin
                phase_next = PH_HALT;
                st_valid   = 1'b1;
                st_code    = ST_SIGNATURE;
                bytes      = (sig_end < 33'(COUNT_CAP)) ? sig_end[15:0] : COUNT_CAP_W;
            end
            else if (hdr_need != CAPTURE_NONE && hdr_len < {29'd0, hdr_need})
            begin
                phase_next = PH_HALT;
                st_valid   = 1'b1;
                st_code    = ST_MALFORMED;
            end
            else
            begin
                value_index_next = 3'd0;
                value_shift_next = 32'd0;
                phase_next       = (hdr_len == 32'd0) ? PH_TAG : PH_VALUE;
            end
        end

        if (!st_valid)
            st_code = (phase_next == PH_TAG || phase_next == PH_LEN1) ? ST_NO_SIGNATURE
                                                                      : ST_TRUNCATED;

        fire = st_valid || (last_byte && phase_reg != PH_HALT);

        result.status         = st_code;
        result.key_identifier = saved_key_id_next;
        result.algorithm      = saved_algorithm_next;
        result.usage_flags    = saved_usage_next;
        result.key_kind       = saved_type_next;
        result.key_size_bits  = saved_bits_next;
        result.lifetime       = saved_lifetime_next;
        result.blob_bytes     = bytes;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg             <= PH_TAG;
            current_tag_reg       <= '0;
            field_length_reg      <= '0;
            length_bytes_left_reg <= '0;
            value_index_reg       <= '0;
            value_shift_reg       <= '0;
            byte_offset_reg       <= '0;
            saved_key_id_reg      <= '0;
            saved_algorithm_reg   <= '0;
            saved_usage_reg       <= '0;
            saved_type_reg        <= '0;
            saved_bits_reg        <= '0;
            saved_lifetime_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg             <= PH_TAG;
                current_tag_reg       <= '0;
                field_length_reg      <= '0;
                length_bytes_left_reg <= '0;
                value_index_reg       <= '0;
                value_shift_reg       <= '0;
                byte_offset_reg       <= '0;
                saved_key_id_reg      <= '0;
                saved_algorithm_reg   <= '0;
                saved_usage_reg       <= '0;
                saved_type_reg        <= '0;
                saved_bits_reg        <= '0;
                saved_lifetime_reg    <= '0;
            end
            else
            begin
                phase_reg             <= phase_next;
                current_tag_reg       <= current_tag_next;
                field_length_reg      <= field_length_next;
                length_bytes_left_reg <= length_bytes_left_next;
                value_index_reg       <= value_index_next;
                value_shift_reg       <= value_shift_next;
                byte_offset_reg       <= byte_offset_next;
                saved_key_id_reg      <= saved_key_id_next;
                saved_algorithm_reg   <= saved_algorithm_next;
                saved_usage_reg       <= saved_usage_next;
                saved_type_reg        <= saved_type_next;
                saved_bits_reg        <= saved_bits_next;
                saved_lifetime_reg    <= saved_lifetime_next;
            end
        end
    end

endmodule

/* sv/tlv_key_attribute_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV key attribute parser
// Streams a key blob byte by byte, captures key attributes from its TLV
// records and reports them when the signature header completes, a record is
// malformed or the blob ends.
//
//   channel   dir   payload
//   blob      in    data_byte, last_byte
//   result    out   status, attributes, blob_bytes
//
// One byte is taken per cycle; a result, when a byte causes one, appears in
// the output register the cycle after its byte is taken.
// Reset clears all parser state and empties the output register.
// A byte is taken while the output register is empty or is being drained in
// the same cycle, so a stalled result holds back only the next byte.
// ----------------------------------------------------------------------------
module tlv_key_attribute_parser (
    input  logic            clk,
    input  logic            rst_n,
    tlvkap_byte_if.sink     blob,
    tlvkap_result_if.source result
);
    import tlvkap_pkg::*;

    logic    accept;
    logic    fire;
    logic    halted;
    result_t core_result;
    logic    out_valid_reg;
    result_t result_reg;

    assign blob.ready = !out_valid_reg || result.ready;
    assign accept     = blob.valid && blob.ready;

    tlvkap_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (blob.data_byte),
        .last_byte (blob.last_byte),
        .fire      (fire),
        .result    (core_result),
        .halted    (halted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && fire)
            result_reg <= core_result;
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = result_reg.status;
    assign result.key_identifier = result_reg.key_identifier;
    assign result.algorithm      = result_reg.algorithm;
    assign result.usage_flags    = result_reg.usage_flags;
    assign result.key_kind       = result_reg.key_kind;
    assign result.key_size_bits  = result_reg.key_size_bits;
    assign result.lifetime       = result_reg.lifetime;
    assign result.blob_bytes     = result_reg.blob_bytes;

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !blob.ready)
        else $error("byte taken while result stalled");

    a_last_byte_reports: assert property (@(posedge clk) disable iff (!rst_n)
        accept && blob.last_byte && !halted |=> result.valid)
        else $error("final byte gave no result");

    a_signature_length: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_SIGNATURE |-> result.blob_bytes >= 16'd2)
        else $error("signature result with impossible length");
`endif

endmodule
